// ===== hw/rtl/plasma_pixel_generator_top_defines.svh =====
// assertion helpers for the plasma pixel generator
// both sample on clk and are disabled while arst_n is low
`ifndef PLASMA_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define PLASMA_PIXEL_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PPG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ppg_pkg.sv =====
package ppg_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;

	localparam int DELTA_W = 16;
	localparam int POS_X_W = 9;
	localparam int POS_Y_W = 8;
	localparam int COLOR_W = 8;

	localparam int FRAME_COUNT = 720;
	localparam int FRAC_BITS   = 8;
	localparam int FRAME_MOD   = FRAME_COUNT << FRAC_BITS;
	localparam int FRAME_W     = 18;

	localparam int COS_FRAC   = 14;
	localparam int BASE_LEVEL = 75;
	localparam int WAVE_W     = 21;
	localparam int SUM_W      = WAVE_W + 1;
	localparam logic signed [SUM_W-1:0] BASE_Q14 = SUM_W'(BASE_LEVEL * (1 << COS_FRAC));

	localparam logic [8:0] DEG_90  = 9'd90;
	localparam logic [8:0] DEG_180 = 9'd180;
	localparam logic [8:0] DEG_270 = 9'd270;
	localparam logic [8:0] DEG_360 = 9'd360;
	localparam logic [9:0] FULL_TURN = 10'd360;

	localparam int QTR_DEPTH = 91;
	localparam int TAYLOR_TERMS = 12;
	localparam longint unsigned PI_Q31 = 64'd6746518852;
	localparam longint unsigned HALF_TURN = 64'd180;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
		'{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		  64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

	typedef logic [8:0] angle_t;
	typedef logic signed [15:0] cos_t;
	typedef logic [WAVE_W-1:0] wave_t;
	typedef logic [14:0] qtr_t [QTR_DEPTH];

	typedef struct packed {
		angle_t fm;   // f mod 360
		angle_t f2m;  // 2f mod 360
		angle_t fh;   // f/2
	} frame_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// quarter-wave cosine in Q1.14, fixed-point taylor series rounded to nearest
	function automatic qtr_t build_qtr();
		qtr_t tbl;
		longint unsigned theta;
		longint unsigned t2;
		longint unsigned term;
		longint unsigned mag;
		longint acc;
		for (int d = 0; d < QTR_DEPTH; d++) begin
			theta = 64'(d) * PI_Q31 / HALF_TURN;
			t2 = (theta * theta) >> 31;
			term = 64'd1 << 31;
			acc = longint'(term);
			for (int k = 1; k <= TAYLOR_TERMS; k++) begin
				term = ((term * t2) >> 31) / TAYLOR_DIV[k-1];
				if (k[0]) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			mag = (64'(acc) + (64'd1 << 16)) >> 17;
			tbl[d] = 15'(mag);
		end
		return tbl;
	endfunction

	localparam qtr_t COS_QTR = build_qtr();

	// reduce a value below 720 to 0..359
	function automatic angle_t fold360(input logic [9:0] v);
		logic [9:0] r;
		r = (v >= FULL_TURN) ? (v - FULL_TURN) : v;
		return r[8:0];
	endfunction

	// full-circle cosine from the quarter table, angle in 0..359
	function automatic cos_t cos_lookup(input angle_t a);
		angle_t idx;
		logic neg;
		cos_t mag;
		if (a <= DEG_90) begin
			idx = a;
			neg = 1'b0;
		end else if (a <= DEG_180) begin
			idx = DEG_180 - a;
			neg = 1'b1;
		end else if (a <= DEG_270) begin
			idx = a - DEG_180;
			neg = 1'b1;
		end else begin
			idx = DEG_360 - a;
			neg = 1'b0;
		end
		mag = {1'b0, COS_QTR[idx[6:0]]};
		return neg ? -mag : mag;
	endfunction

endpackage

// ===== hw/rtl/ppg_if.sv =====
interface ppg_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [ppg_pkg::DELTA_W-1:0] delta_frames;
	logic [ppg_pkg::POS_X_W-1:0] pos_x;
	logic [ppg_pkg::POS_Y_W-1:0] pos_y;

	modport source(output valid, mode, delta_frames, pos_x, pos_y, input ready);
	modport sink(input valid, mode, delta_frames, pos_x, pos_y, output ready);
endinterface

interface ppg_out_if;
	logic                        valid;
	logic                        ready;
	logic [ppg_pkg::COLOR_W-1:0] color_index;
	logic [ppg_pkg::COLOR_W-1:0] red;
	logic [ppg_pkg::COLOR_W-1:0] green;
	logic [ppg_pkg::COLOR_W-1:0] blue;

	modport source(output valid, color_index, red, green, blue, input ready);
	modport sink(input valid, color_index, red, green, blue, output ready);
endinterface

// ===== hw/rtl/ppg_frame_acc.sv =====
module ppg_frame_acc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick,
	input  logic [ppg_pkg::DELTA_W-1:0] delta_frames,
	output ppg_pkg::frame_t             frame
);

	logic [ppg_pkg::FRAME_W-1:0] frame_pos_q;
	logic [ppg_pkg::FRAME_W-1:0] sum;
	logic [ppg_pkg::FRAME_W-1:0] frame_next;
	logic [ppg_pkg::FRAME_W-ppg_pkg::FRAC_BITS-1:0] whole;

	// sum stays below twice the wrap point, one subtract is enough
	always_comb begin
		sum = frame_pos_q + ppg_pkg::FRAME_W'(delta_frames);
		if (sum >= ppg_pkg::FRAME_W'(ppg_pkg::FRAME_MOD)) begin
			frame_next = sum - ppg_pkg::FRAME_W'(ppg_pkg::FRAME_MOD);
		end else begin
			frame_next = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q <= '0;
		end else if (tick) begin
			frame_pos_q <= frame_next;
		end
	end

	// integer frame and its angle offsets
	always_comb begin
		whole = frame_pos_q[ppg_pkg::FRAME_W-1:ppg_pkg::FRAC_BITS];
		frame.fm = ppg_pkg::fold360(whole);
		frame.f2m = ppg_pkg::fold360({frame.fm, 1'b0});
		frame.fh = whole[9:1];
	end

endmodule

// ===== hw/rtl/ppg_wave_sum.sv =====
module ppg_wave_sum (
	input  logic                        clk,
	input  ppg_pkg::stage_en_t          en,
	input  logic [ppg_pkg::POS_X_W-1:0] pos_x,
	input  logic [ppg_pkg::POS_Y_W-1:0] pos_y,
	input  ppg_pkg::frame_t             frame,
	output ppg_pkg::wave_t              xc_s3,
	output ppg_pkg::wave_t              yc_s3
);

	localparam int N_ANG = 6;

	ppg_pkg::angle_t xm;
	ppg_pkg::angle_t x2m;
	ppg_pkg::angle_t y2m;
	logic [7:0]      xh;
	ppg_pkg::angle_t ang [N_ANG];
	ppg_pkg::angle_t angle_s2 [N_ANG];
	logic signed [ppg_pkg::SUM_W-1:0] cv [N_ANG];
	logic signed [ppg_pkg::SUM_W-1:0] xsum;
	logic signed [ppg_pkg::SUM_W-1:0] ysum;

	// angles for the six cosine terms, each reduced to 0..359
	always_comb begin
		xm = ppg_pkg::fold360(10'(pos_x));
		x2m = ppg_pkg::fold360({xm, 1'b0});
		xh = pos_x[8:1];
		y2m = ppg_pkg::fold360({1'b0, pos_y, 1'b0});
		ang[0] = ppg_pkg::fold360(10'(pos_y) + 10'(frame.f2m));
		ang[1] = ppg_pkg::fold360(10'(y2m) + 10'(frame.fh));
		ang[2] = ppg_pkg::fold360(10'(pos_y) + 10'(frame.fm));
		ang[3] = ppg_pkg::fold360(10'(x2m) + 10'(frame.fh));
		ang[4] = ppg_pkg::fold360(10'(xm) + 10'(frame.f2m));
		ang[5] = ppg_pkg::fold360(10'(xh) + 10'(frame.fm));
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			angle_s2 <= ang;
		end
	end

	// cosine terms and the two wave sums, always positive
	always_comb begin
		for (int i = 0; i < N_ANG; i++) begin
			cv[i] = ppg_pkg::SUM_W'(ppg_pkg::cos_lookup(angle_s2[i]));
		end
		ysum = ppg_pkg::BASE_Q14 + (cv[0] <<< 1) + cv[1] + (cv[2] <<< 1);
		xsum = ppg_pkg::BASE_Q14 + cv[3] + cv[4] + (cv[5] <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			xc_s3 <= xsum[ppg_pkg::WAVE_W-1:0];
			yc_s3 <= ysum[ppg_pkg::WAVE_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/ppg_shade.sv =====
module ppg_shade (
	input  logic                        clk,
	input  ppg_pkg::stage_en_t          en,
	input  ppg_pkg::wave_t              xc_s3,
	input  ppg_pkg::wave_t              yc_s3,
	output logic [ppg_pkg::COLOR_W-1:0] color_index_s5,
	output ppg_pkg::rgb_t               rgb_s5
);

	localparam int PROD_W = 2 * ppg_pkg::WAVE_W;
	localparam int IDX_LSB = 2 * ppg_pkg::COS_FRAC;

	localparam logic [7:0] RAMP_1  = 8'd42;
	localparam logic [7:0] RAMP_2  = 8'd84;
	localparam logic [7:0] RAMP_3  = 8'd126;
	localparam logic [7:0] RAMP_4  = 8'd168;
	localparam logic [7:0] RAMP_5  = 8'd210;
	localparam logic [7:0] PAL_END = 8'd252;
	localparam logic [5:0] RAMP_TOP = 6'd42;

	logic [PROD_W-1:0] prod;
	logic [7:0]        idx_s4;

	// six ramps: to red, yellow, white, cyan, blue, then black
	function automatic ppg_pkg::rgb_t shade_of(input logic [7:0] i);
		logic [5:0] r;
		logic [5:0] g;
		logic [5:0] b;
		ppg_pkg::rgb_t c;
		r = '0;
		g = '0;
		b = '0;
		if (i < RAMP_1) begin
			r = i[5:0];
		end else if (i < RAMP_2) begin
			r = RAMP_TOP;
			g = 6'(i - RAMP_1);
		end else if (i < RAMP_3) begin
			r = RAMP_TOP;
			g = RAMP_TOP;
			b = 6'(i - RAMP_2);
		end else if (i < RAMP_4) begin
			r = RAMP_TOP - 6'(i - RAMP_3);
			g = RAMP_TOP;
			b = RAMP_TOP;
		end else if (i < RAMP_5) begin
			g = RAMP_TOP - 6'(i - RAMP_4);
			b = RAMP_TOP;
		end else if (i < PAL_END) begin
			b = RAMP_TOP - 6'(i - RAMP_5);
		end
		c.red = {r, 2'b00};
		c.green = {g, 2'b00};
		c.blue = {b, 2'b00};
		return c;
	endfunction

	assign prod = PROD_W'(xc_s3) * PROD_W'(yc_s3);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			idx_s4 <= prod[IDX_LSB +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			color_index_s5 <= idx_s4;
			rgb_s5 <= shade_of(idx_s4);
		end
	end

endmodule

// ===== hw/rtl/plasma_pixel_generator_top.sv =====
// plasma pixel generator: cosine-table plasma with a palette lookup
// a pixel word taken on cmd is registered in s1, s2, s3, s4 and s5 in turn before it appears on pix
// throughput: one word per cycle while pix is ready, set by the five-stage pipeline with per-stage valid bits
// tick words update the frame accumulator at once and produce no result
// reset: arst_n clears the frame accumulator and every stage valid bit
`include "plasma_pixel_generator_top_defines.svh"

module plasma_pixel_generator_top (
	input  logic      clk,
	input  logic      arst_n,
	ppg_in_if.sink    cmd,
	ppg_out_if.source pix
);

	// stage plan
	//   s1: captured pixel position and frame angle offsets
	//   s2: six angles reduced to 0..359
	//   s3: cosine lookup and the xc / yc wave sums
	//   s4: xc*yc product, palette index
	//   s5: palette color, drives the result port

	logic accept;
	logic tick;
	logic on_screen;
	logic load_s1;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;

	// a stage may load when it is empty or its word moves on this cycle
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic ready_s4;
	logic ready_s5;

	logic [ppg_pkg::POS_X_W-1:0] pos_x_s1;
	logic [ppg_pkg::POS_Y_W-1:0] pos_y_s1;
	ppg_pkg::frame_t             frame;
	ppg_pkg::frame_t             frame_s1;
	ppg_pkg::stage_en_t          en;
	ppg_pkg::wave_t              xc_s3;
	ppg_pkg::wave_t              yc_s3;
	logic [ppg_pkg::COLOR_W-1:0] color_index_s5;
	ppg_pkg::rgb_t               rgb_s5;

	// backpressure ripples from the result port toward the input
	assign ready_s5 = !valid_s5 || pix.ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign cmd.ready = ready_s1;
	assign accept = cmd.valid && ready_s1;
	assign tick = accept && !cmd.mode;

	// off-screen pixels are dropped at the input
	assign on_screen = (13'(cmd.pos_x) < 13'(ppg_pkg::SCREEN_WIDTH)) &&
		(13'(cmd.pos_y) < 13'(ppg_pkg::SCREEN_HEIGHT));
	assign load_s1 = accept && cmd.mode && on_screen;

	// data enables only fire when a word actually moves in
	assign en.s2 = ready_s2 && valid_s1;
	assign en.s3 = ready_s3 && valid_s2;
	assign en.s4 = ready_s4 && valid_s3;
	assign en.s5 = ready_s5 && valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= load_s1;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// the frame seen by a pixel is the one left by all earlier ticks
	always_ff @(posedge clk) begin
		if (load_s1) begin
			pos_x_s1 <= cmd.pos_x;
			pos_y_s1 <= cmd.pos_y;
			frame_s1 <= frame;
		end
	end

	ppg_frame_acc u_frame_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.delta_frames (cmd.delta_frames),
		.frame        (frame)
	);

	ppg_wave_sum u_wave_sum (
		.clk   (clk),
		.en    (en),
		.pos_x (pos_x_s1),
		.pos_y (pos_y_s1),
		.frame (frame_s1),
		.xc_s3 (xc_s3),
		.yc_s3 (yc_s3)
	);

	ppg_shade u_shade (
		.clk            (clk),
		.en             (en),
		.xc_s3          (xc_s3),
		.yc_s3          (yc_s3),
		.color_index_s5 (color_index_s5),
		.rgb_s5         (rgb_s5)
	);

	assign pix.valid = valid_s5;
	assign pix.color_index = color_index_s5;
	assign pix.red = rgb_s5.red;
	assign pix.green = rgb_s5.green;
	assign pix.blue = rgb_s5.blue;

	// frame offsets always land inside one turn
	`PPG_ASSERT_NOW(a_fm_fold, 1'b1, frame.fm < ppg_pkg::DEG_360, "fm out of range")
	`PPG_ASSERT_NOW(a_f2m_fold, 1'b1, frame.f2m < ppg_pkg::DEG_360, "f2m out of range")
	`PPG_ASSERT_NOW(a_fh_fold, 1'b1, frame.fh < ppg_pkg::DEG_360, "fh out of range")

	// ticks and off-screen pixels never occupy the pipeline
	`PPG_ASSERT_NEXT(a_drop_no_entry, accept && !load_s1, !valid_s1, "dropped word entered")

	// a word leaving the product stage lands in the result register
	`PPG_ASSERT_NEXT(a_s4_to_s5, valid_s4 && ready_s5, valid_s5, "word lost before result")

endmodule
